[rtl/dct_pkg.sv]
// Shared types, constants and the coefficient table of the 8x8 DCT block.
package dct_pkg;

  localparam int unsigned ROW_SHIFT = 14;
  localparam int unsigned COL_SHIFT = 16;

  localparam logic signed [15:0] K_C1 = 16'sd16070;
  localparam logic signed [15:0] K_C2 = 16'sd15137;
  localparam logic signed [15:0] K_C3 = 16'sd13623;
  localparam logic signed [15:0] K_C4 = 16'sd11586;
  localparam logic signed [15:0] K_C5 = 16'sd9103;
  localparam logic signed [15:0] K_C6 = 16'sd6270;
  localparam logic signed [15:0] K_C7 = 16'sd3197;

  // Operand slots of the multiply-accumulate unit.
  localparam logic [2:0] OP_B07 = 3'd0;
  localparam logic [2:0] OP_B16 = 3'd1;
  localparam logic [2:0] OP_B25 = 3'd2;
  localparam logic [2:0] OP_B34 = 3'd3;
  localparam logic [2:0] OP_SUM = 3'd4;
  localparam logic [2:0] OP_DIF = 3'd5;
  localparam logic [2:0] OP_F0  = 3'd6;
  localparam logic [2:0] OP_F1  = 3'd7;

  typedef struct packed {
    logic [2:0]        sel;
    logic signed [15:0] coef;
  } term_t;

  typedef struct packed {
    logic       wr_pix;
    logic [5:0] wr_addr;
    logic       rd_en;
    logic       rd_sel;
    logic [5:0] rd_addr;
    logic [2:0] slot;
    logic       bfa;
    logic       bfe;
    logic       mac_en;
    logic [2:0] k;
    logic [1:0] j;
    logic [2:0] line;
    logic       pass;
  } cmd_t;

  typedef struct packed {
    logic [15:0] rd_data;
  } status_t;

  // Output k of the butterfly is the sum of four terms j.
  function automatic term_t term_of(input logic [2:0] k, input logic [1:0] j);
    term_t t;
    t.sel = {1'b0, j};
    t.coef = 16'sd0;
    case ({k, j})
      5'b001_00: t.coef = K_C1;
      5'b001_01: t.coef = K_C3;
      5'b001_10: t.coef = K_C5;
      5'b001_11: t.coef = K_C7;
      5'b011_00: t.coef = K_C3;
      5'b011_01: t.coef = -K_C7;
      5'b011_10: t.coef = -K_C1;
      5'b011_11: t.coef = -K_C5;
      5'b101_00: t.coef = K_C5;
      5'b101_01: t.coef = -K_C1;
      5'b101_10: t.coef = K_C7;
      5'b101_11: t.coef = K_C3;
      5'b111_00: t.coef = K_C7;
      5'b111_01: t.coef = -K_C5;
      5'b111_10: t.coef = K_C3;
      5'b111_11: t.coef = -K_C1;
      5'b000_00: begin
        t.sel = OP_SUM;
        t.coef = K_C4;
      end
      5'b100_00: begin
        t.sel = OP_DIF;
        t.coef = K_C4;
      end
      5'b010_00: begin
        t.sel = OP_F0;
        t.coef = K_C2;
      end
      5'b010_01: begin
        t.sel = OP_F1;
        t.coef = K_C6;
      end
      5'b110_00: begin
        t.sel = OP_F0;
        t.coef = K_C6;
      end
      5'b110_01: begin
        t.sel = OP_F1;
        t.coef = -K_C2;
      end
      default: t.coef = 16'sd0;
    endcase
    return t;
  endfunction

endpackage

[rtl/dct_ctrl.sv]
// Sequencer of the DCT block: collection, two passes of eight butterflies, readout.
module dct_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            sample_valid,
  output logic            sample_ready,
  output logic            result_valid,
  input  logic            result_ready,
  output logic [5:0]      position,
  output logic            last,
  output dct_pkg::cmd_t   cmd
);
  import dct_pkg::*;

  typedef enum logic [2:0] {
    S_COLLECT, S_LOAD, S_BFA, S_BFE, S_MAC, S_DRAIN, S_OUT_RD, S_OUT_SHOW
  } state_t;

  state_t     state;
  logic [5:0] cnt;
  logic [2:0] line;
  logic       pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
      cnt   <= '0;
      line  <= '0;
      pass  <= 1'b0;
    end else begin
      unique case (state)
        S_COLLECT: begin
          if (sample_valid) begin
            cnt <= cnt + 6'd1;
            if (cnt == 6'd63) begin
              state <= S_LOAD;
              line  <= '0;
              pass  <= 1'b0;
            end
          end
        end
        S_LOAD: begin
          if (cnt == 6'd8) begin
            cnt   <= '0;
            state <= S_BFA;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_BFA: state <= S_BFE;
        S_BFE: state <= S_MAC;
        S_MAC: begin
          if (cnt == 6'd31) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DRAIN: begin
          if (cnt == 6'd2) begin
            cnt <= '0;
            if (line == 3'd7) begin
              line <= '0;
              if (pass) begin
                state <= S_OUT_RD;
              end else begin
                pass  <= 1'b1;
                state <= S_LOAD;
              end
            end else begin
              line  <= line + 3'd1;
              state <= S_LOAD;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_OUT_RD: state <= S_OUT_SHOW;
        S_OUT_SHOW: begin
          if (result_ready) begin
            cnt <= cnt + 6'd1;
            if (cnt == 6'd63) begin
              state <= S_COLLECT;
            end
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  assign sample_ready = (state == S_COLLECT);
  assign result_valid = (state == S_OUT_SHOW);
  assign position     = cnt;
  assign last         = (cnt == 6'd63);

  always_comb begin
    cmd         = '0;
    cmd.line    = line;
    cmd.pass    = pass;
    cmd.wr_addr = cnt;
    cmd.k       = cnt[4:2];
    cmd.j       = cnt[1:0];
    cmd.slot    = cnt[2:0];
    unique case (state)
      S_COLLECT: cmd.wr_pix = sample_valid;
      S_LOAD: begin
        cmd.rd_en   = (cnt < 6'd8);
        cmd.rd_sel  = pass;
        cmd.rd_addr = pass ? {cnt[2:0], line} : {line, cnt[2:0]};
      end
      S_BFA: cmd.bfa = 1'b1;
      S_BFE: cmd.bfe = 1'b1;
      S_MAC: cmd.mac_en = 1'b1;
      S_DRAIN: cmd.mac_en = 1'b0;
      S_OUT_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = cnt;
      end
      S_OUT_SHOW: begin
        cmd.rd_en   = result_ready && (cnt != 6'd63);
        cmd.rd_addr = cnt + 6'd1;
      end
      default: cmd.rd_en = 1'b0;
    endcase
  end

endmodule

[rtl/dct_datapath.sv]
// Block stores, butterfly registers and the shared multiply-accumulate unit.
module dct_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic signed [15:0]     sample,
  input  dct_pkg::cmd_t          cmd,
  output dct_pkg::status_t       status
);
  import dct_pkg::*;

  logic [15:0] pix_mem [64];
  logic [15:0] row_mem [64];
  logic [15:0] rd_data;

  logic              rd_en_d;
  logic [2:0]        slot_d;
  logic signed [15:0] v [8];
  logic signed [15:0] a [4];
  logic signed [16:0] opnd [8];

  logic signed [15:0] e0, e1, f0, f1;
  logic signed [16:0] e0x, e1x;

  term_t              term;
  logic signed [32:0] prod;
  logic signed [33:0] acc;
  logic signed [33:0] acc_sh;
  logic               v1, first1, last1, v2last;
  logic [2:0]         k1, k2;
  logic [5:0]         res_addr;

  // Store reads and the gather of one line into the butterfly inputs.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= cmd.rd_sel ? row_mem[cmd.rd_addr] : pix_mem[cmd.rd_addr];
    end
    if (rd_en_d) begin
      v[slot_d] <= rd_data;
    end
    slot_d <= cmd.slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_en_d <= 1'b0;
      v1      <= 1'b0;
      v2last  <= 1'b0;
    end else begin
      rd_en_d <= cmd.rd_en && !cmd.pass ? 1'b1 : cmd.rd_en;
      v1      <= cmd.mac_en;
      v2last  <= v1 && last1;
    end
  end

  // First butterfly stage: sums and differences of mirrored pairs.
  always_ff @(posedge clk) begin
    if (cmd.bfa) begin
      for (int i = 0; i < 4; i++) begin
        a[i]    <= v[i] + v[7-i];
        opnd[i] <= 17'(signed'(v[i] - v[7-i]));
      end
    end
  end

  assign e0  = a[0] + a[3];
  assign f0  = a[0] - a[3];
  assign e1  = a[1] + a[2];
  assign f1  = a[1] - a[2];
  assign e0x = 17'(e0);
  assign e1x = 17'(e1);

  // Second stage: the even half, with the C4 operands at full width.
  always_ff @(posedge clk) begin
    if (cmd.bfe) begin
      opnd[OP_SUM] <= e0x + e1x;
      opnd[OP_DIF] <= e0x - e1x;
      opnd[OP_F0]  <= 17'(f0);
      opnd[OP_F1]  <= 17'(f1);
    end
  end

  assign term   = term_of(cmd.k, cmd.j);
  assign acc_sh = cmd.pass ? (acc >>> COL_SHIFT) : (acc >>> ROW_SHIFT);
  assign res_addr = cmd.pass ? {k2, cmd.line} : {cmd.line, k2};

  // Multiply, then accumulate four terms per output.
  always_ff @(posedge clk) begin
    prod   <= opnd[term.sel] * term.coef;
    first1 <= (cmd.j == 2'd0);
    last1  <= (cmd.j == 2'd3);
    k1     <= cmd.k;
    if (v1) begin
      acc <= first1 ? 34'(prod) : acc + 34'(prod);
      k2  <= k1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_pix) begin
      pix_mem[cmd.wr_addr] <= sample;
    end else if (v2last && cmd.pass) begin
      pix_mem[res_addr] <= acc_sh[15:0];
    end
    if (v2last && !cmd.pass) begin
      row_mem[res_addr] <= acc_sh[15:0];
    end
  end

  assign status.rd_data = rd_data;

endmodule

[rtl/dct_8x8_fixed_point_top.sv]
// Top level of the fixed-point 8x8 forward DCT.
// After the 64th sample item the row pass and then the column pass run; after the read
// state, coefficients leave one per cycle while result_ready is high.
// No new sample item is taken until the last coefficient of the block has left; the
// single shared multiplier, used for every butterfly, sets the transform time.
// Reset: rst is synchronous and active high; it clears the sequencer, the stores are
// not cleared and are always fully written before they are read.
module dct_8x8_fixed_point_top (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [15:0] sample,
  input  logic               sample_valid,
  output logic               sample_ready,
  output logic signed [15:0] coefficient,
  output logic [5:0]         position,
  output logic               last,
  output logic               result_valid,
  input  logic               result_ready
);
  import dct_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The sequencer owns all handshakes; the datapath only follows its commands.
  dct_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .position     (position),
    .last         (last),
    .cmd          (cmd)
  );

  // The pixel store doubles as the coefficient buffer after the column pass.
  dct_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .cmd    (cmd),
    .status (status)
  );

  assign coefficient = signed'(status.rd_data);

endmodule

[rtl/dct_checker.sv]
// Port-level assertions of the DCT block and the bind that attaches them.
module dct_checker (
  input logic               clk,
  input logic               rst,
  input logic signed [15:0] sample,
  input logic               sample_valid,
  input logic               sample_ready,
  input logic signed [15:0] coefficient,
  input logic [5:0]         position,
  input logic               last,
  input logic               result_valid,
  input logic               result_ready
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(sample_ready && result_valid))
    else $error("input and output active together");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last == (position == 6'd63)))
    else $error("last flag does not match position");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !last) |=>
      (result_valid && position == $past(position) + 6'd1))
    else $error("coefficient position did not advance");

  a_end_block: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && last) |=> (!result_valid && sample_ready))
    else $error("block did not return to collection");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(coefficient)))
    else $error("stalled coefficient changed");

endmodule

bind dct_8x8_fixed_point_top dct_checker u_chk (.*);

[tb/dct_8x8_fixed_point_top_tb.sv]
// Self-checking testbench of the 8x8 fixed-point forward DCT top level.
module dct_8x8_fixed_point_top_tb;
  import dct_pkg::*;

  typedef struct {
    logic signed [15:0] coefficient;
    logic [5:0]         position;
    logic               last;
  } coef_item_t;

  // Keeps its own copy of the pixel block and predicts the 64 coefficients
  // that follow the 64th pixel; results are checked in order.
  class dct_scoreboard;
    logic signed [15:0] pixels[64];
    int                 fill;
    coef_item_t         pending_coefs[$];
    int                 errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    // Wraps a 32-bit value to a signed 16-bit value.
    function int wrap16(int v);
      logic signed [15:0] w;
      w = v[15:0];
      return int'(w);
    endfunction

    // One 8-point butterfly with arithmetic right shift by sh.
    function void butterfly(ref int v[8], input int sh);
      int a07, a16, a25, a34, b07, b16, b25, b34, e0, e1, f0, f1;
      int r[8];
      a07 = wrap16(v[0] + v[7]); b07 = wrap16(v[0] - v[7]);
      a16 = wrap16(v[1] + v[6]); b16 = wrap16(v[1] - v[6]);
      a25 = wrap16(v[2] + v[5]); b25 = wrap16(v[2] - v[5]);
      a34 = wrap16(v[3] + v[4]); b34 = wrap16(v[3] - v[4]);
      r[1] = (16070 * b07 + 13623 * b16 + 9103 * b25 + 3197 * b34) >>> sh;
      r[3] = (13623 * b07 - 3197 * b16 - 16070 * b25 - 9103 * b34) >>> sh;
      r[5] = (9103 * b07 - 16070 * b16 + 3197 * b25 + 13623 * b34) >>> sh;
      r[7] = (3197 * b07 - 9103 * b16 + 13623 * b25 - 16070 * b34) >>> sh;
      e0 = wrap16(a07 + a34); f0 = wrap16(a07 - a34);
      e1 = wrap16(a16 + a25); f1 = wrap16(a16 - a25);
      // The DC and mid terms sum their operands at full width first.
      r[0] = (11586 * (e0 + e1)) >>> sh;
      r[4] = (11586 * (e0 - e1)) >>> sh;
      r[2] = (15137 * f0 + 6270 * f1) >>> sh;
      r[6] = (6270 * f0 - 15137 * f1) >>> sh;
      foreach (r[k]) v[k] = wrap16(r[k]);
    endfunction

    function void note_sample(logic signed [15:0] s);
      int blk[64];
      int line[8];
      coef_item_t c;
      pixels[fill] = s;
      fill = (fill + 1) % 64;
      if (fill != 0) return;
      foreach (blk[i]) blk[i] = int'(pixels[i]);
      for (int r = 0; r < 8; r++) begin
        for (int k = 0; k < 8; k++) line[k] = blk[r * 8 + k];
        butterfly(line, ROW_SHIFT);
        for (int k = 0; k < 8; k++) blk[r * 8 + k] = line[k];
      end
      for (int col = 0; col < 8; col++) begin
        for (int k = 0; k < 8; k++) line[k] = blk[k * 8 + col];
        butterfly(line, COL_SHIFT);
        for (int k = 0; k < 8; k++) blk[k * 8 + col] = line[k];
      end
      for (int i = 0; i < 64; i++) begin
        c.coefficient = blk[i][15:0];
        c.position = i[5:0];
        c.last = (i == 63);
        pending_coefs.push_back(c);
      end
    endfunction

    function void check_coef(logic signed [15:0] coef, logic [5:0] pos, logic lst);
      coef_item_t e;
      if (pending_coefs.size() == 0) begin
        $display("%0t: unexpected coefficient item %0d at %0d", $time, coef, pos);
        errors++;
        return;
      end
      e = pending_coefs.pop_front();
      if (coef !== e.coefficient || pos !== e.position || lst !== e.last) begin
        $display("%0t: mismatch expected coef=%0d pos=%0d last=%0b %s%0d pos=%0d last=%0b",
                 $time, e.coefficient, e.position, e.last, "actual coef=",
                 coef, pos, lst);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic signed [15:0] sample;
  logic               sample_valid;
  logic               sample_ready;
  logic signed [15:0] coefficient;
  logic [5:0]         position;
  logic               last;
  logic               result_valid;
  logic               result_ready;

  dct_scoreboard board;
  // Idle percentages of sender and receiver, changed between phases.
  int  send_idle_pct;
  int  recv_idle_pct;
  // While set, the receiver holds off completely for a counted stretch.
  bit  hold_request;

  dct_8x8_fixed_point_top uut (
    .clk(clk),
    .rst(rst),
    .sample(sample),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .coefficient(coefficient),
    .position(position),
    .last(last),
    .result_valid(result_valid),
    .result_ready(result_ready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

  // Both handshakes are sampled at the rising edge; the scoreboard sees each
  // accepted item in the order the block takes it.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready) board.note_sample(sample);
      if (result_valid && result_ready) board.check_coef(coefficient, position, last);
    end
  end

  // Receiver: draws ready at each falling edge, or holds off when asked.
  initial begin
    int hold_cycles;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        // Long stall counted here so the block backs up and stalls its input.
        result_ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 3000) begin
          @(negedge clk);
          hold_cycles++;
        end
        hold_request = 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one pixel item and waits until it is accepted; the valid stays high
  // between back-to-back items and drops only while the sender idles.
  task automatic send_pixel(logic signed [15:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample <= px;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends a whole block; shape picks a kind of content.
  task automatic send_block(int shape);
    logic signed [15:0] px;
    for (int i = 0; i < 64; i++) begin
      case (shape)
        0: px = 16'sh7fff;
        1: px = 16'sh8000;
        2: px = (i[0] ^ i[3]) ? 16'sh7fff : 16'sh8000;
        3: px = 16'sd0;
        4: px = 16'(int'($urandom_range(255)) - 128);
        default: px = 16'($urandom);
      endcase
      send_pixel(px);
    end
  endtask

  task automatic wait_drained();
    while (board.pending_coefs.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    sample = '0;
    sample_valid = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed block: alternating extremes that drive the butterfly differences to wrap.
    send_block(2);
    sample_valid <= 1'b0;
    wait_drained();

    // The receiver holds off for a long stretch while the sender keeps offering
    // items, so the block fills up and stalls its input.
    hold_request = 1'b1;
    send_block(0);

    send_idle_pct = 35;
    recv_idle_pct = 71;
    send_block(4);
    send_idle_pct = 71;
    recv_idle_pct = 35;
    send_block(5);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_block(1);
    // A trailing partial block must produce no coefficients.
    for (int i = 0; i < 40; i++) send_pixel(16'($urandom));
    sample_valid <= 1'b0;
    wait_drained();
    repeat (800) @(negedge clk);

    if (board.errors == 0 && board.pending_coefs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
